// ===== design/mi3_pkg.sv =====
package mi3_pkg;

    // number of matrix entries carried by one word
    localparam int NUM_ENT = 9;

    // adjugate entry k = m[MIN_A] * m[MIN_B] - m[MIN_C] * m[MIN_D], row-major indexes
    localparam int MIN_A [NUM_ENT] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
    localparam int MIN_B [NUM_ENT] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
    localparam int MIN_C [NUM_ENT] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
    localparam int MIN_D [NUM_ENT] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

    // determinant expands along the first row: m[k] * adj[DET_ADJ[k]]
    localparam int DET_TERMS = 3;
    localparam int DET_ADJ [DET_TERMS] = '{0, 3, 6};

    // width of the threshold register
    localparam int THR_WIDTH = 31;

    // reset value of the threshold register (1.0 lsb of Q.F)
    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

endpackage

// ===== design/mi3_if.sv =====
interface mi3_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_r1c1;
    logic signed [W-1:0] in_r1c2;
    logic signed [W-1:0] in_r1c3;
    logic signed [W-1:0] in_r2c1;
    logic signed [W-1:0] in_r2c2;
    logic signed [W-1:0] in_r2c3;
    logic signed [W-1:0] in_r3c1;
    logic signed [W-1:0] in_r3c2;
    logic signed [W-1:0] in_r3c3;

    modport source (output valid, in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3,
                    in_r3c1, in_r3c2, in_r3c3, input ready);
    modport sink   (input valid, in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3,
                    in_r3c1, in_r3c2, in_r3c3, output ready);
endinterface

interface mi3_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_r1c1;
    logic signed [W-1:0] out_r1c2;
    logic signed [W-1:0] out_r1c3;
    logic signed [W-1:0] out_r2c1;
    logic signed [W-1:0] out_r2c2;
    logic signed [W-1:0] out_r2c3;
    logic signed [W-1:0] out_r3c1;
    logic signed [W-1:0] out_r3c2;
    logic signed [W-1:0] out_r3c3;
    logic                singular;
    logic                saturated;

    modport source (output valid, out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2,
                    out_r2c3, out_r3c1, out_r3c2, out_r3c3, singular, saturated,
                    input ready);
    modport sink   (input valid, out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2,
                    out_r2c3, out_r3c1, out_r3c2, out_r3c3, singular, saturated,
                    output ready);
endinterface

interface mi3_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mi3_pkg::THR_WIDTH-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/mi3_front.sv =====
module mi3_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                              i_clk,
    input  logic [5:0]                        i_en,
    input  logic signed [W-1:0]               i_ent [mi3_pkg::NUM_ENT],
    input  logic [mi3_pkg::THR_WIDTH-1:0]     i_thr,
    output logic [3*W+1:0]                    o_mag,
    output logic [2*W+2*F:0]                  o_num [mi3_pkg::NUM_ENT],
    output logic                              o_neg [mi3_pkg::NUM_ENT],
    output logic                              o_sing,
    output logic signed [W-1:0]               o_ent [mi3_pkg::NUM_ENT]
);

    localparam int NE = mi3_pkg::NUM_ENT;
    localparam int AW = 2 * W + 1;
    localparam int LB = W + 1;
    localparam int DW = 3 * W + 2;
    localparam int NW = AW + 2 * F;
    localparam int TW = DW + 2 * F + mi3_pkg::THR_WIDTH;

    logic signed [W-1:0]    r_m0 [NE];
    logic signed [W-1:0]    r_m1 [NE];
    logic signed [W-1:0]    r_m2 [NE];
    logic signed [W-1:0]    r_m3 [NE];
    logic signed [W-1:0]    r_m4 [NE];
    logic signed [W-1:0]    r_m5 [NE];
    logic signed [2*W-1:0]  r_p [NE];
    logic signed [2*W-1:0]  r_s [NE];
    logic signed [AW-1:0]   r_adj2 [NE];
    logic signed [AW-1:0]   r_adj3 [NE];
    logic signed [AW-1:0]   r_adj4 [NE];
    logic signed [2*W+1:0]  r_plo [mi3_pkg::DET_TERMS];
    logic signed [2*W-1:0]  r_phi [mi3_pkg::DET_TERMS];
    logic signed [DW-1:0]   r_det;
    logic [DW-1:0]          r_mag;
    logic [NW-1:0]          r_num [NE];
    logic                   r_neg [NE];
    logic                   r_sing;

    logic signed [DW-1:0]   w_det;
    logic [DW-1:0]          w_mag;
    logic [TW-1:0]          w_lim;

    // capture the matrix word
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m0 <= i_ent;
        end
    end

    // minor products
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < NE; k++) begin
                r_p[k] <= r_m0[mi3_pkg::MIN_A[k]] * r_m0[mi3_pkg::MIN_B[k]];
                r_s[k] <= r_m0[mi3_pkg::MIN_C[k]] * r_m0[mi3_pkg::MIN_D[k]];
            end
            r_m1 <= r_m0;
        end
    end

    // adjugate entries, exact
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int k = 0; k < NE; k++) begin
                r_adj2[k] <= AW'(r_p[k]) - AW'(r_s[k]);
            end
            r_m2 <= r_m1;
        end
    end

    // determinant partial products, adjugate split into low and high halves
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int k = 0; k < mi3_pkg::DET_TERMS; k++) begin
                r_plo[k] <= r_m2[k] * $signed({1'b0, r_adj2[mi3_pkg::DET_ADJ[k]][LB-1:0]});
                r_phi[k] <= r_m2[k] * $signed(r_adj2[mi3_pkg::DET_ADJ[k]][AW-1:LB]);
            end
            r_adj3 <= r_adj2;
            r_m3   <= r_m2;
        end
    end

    // determinant sum
    always_comb begin
        w_det = '0;
        for (int k = 0; k < mi3_pkg::DET_TERMS; k++) begin
            w_det = w_det + DW'(r_plo[k]) + (DW'(r_phi[k]) <<< LB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_det  <= w_det;
            r_adj4 <= r_adj3;
            r_m4   <= r_m3;
        end
    end

    // magnitudes, signs and the singular test
    assign w_mag = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
    assign w_lim = TW'(i_thr) << (2 * F);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_mag  <= w_mag;
            r_sing <= (w_mag == '0) || (TW'(w_mag) < w_lim);
            for (int k = 0; k < NE; k++) begin
                r_num[k] <= {(r_adj4[k][AW-1] ? AW'(-r_adj4[k]) : AW'(r_adj4[k])),
                             {(2 * F){1'b0}}};
                r_neg[k] <= r_adj4[k][AW-1] ^ r_det[DW-1];
            end
            r_m5 <= r_m4;
        end
    end

    assign o_mag  = r_mag;
    assign o_num  = r_num;
    assign o_neg  = r_neg;
    assign o_sing = r_sing;
    assign o_ent  = r_m5;

endmodule

// ===== design/mi3_div_lane.sv =====
module mi3_div_lane #(
    parameter int W  = 32,
    parameter int NW = 97,
    parameter int MW = 98
) (
    input  logic            i_clk,
    input  logic [W:0]      i_en,
    input  logic [NW-1:0]   i_num,
    input  logic [MW-1:0]   i_den,
    input  logic            i_neg,
    output logic [W-1:0]    o_q,
    output logic            o_ovf,
    output logic            o_neg
);

    localparam int CW = (NW > MW + W) ? NW : MW + W;

    logic [CW-1:0] r_rem [W+1];
    logic [MW-1:0] r_den [W+1];
    logic [W-1:0]  r_q   [W+1];
    logic          r_ovf [W+1];
    logic          r_neg [W+1];

    // entry: quotient too wide for the result when num >= den * 2^W
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << W);
            r_neg[0] <= i_neg;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar j = 1; j <= W; j++) begin : g_step
        localparam int B = W - j;
        logic [CW:0] w_dif;

        assign w_dif = {1'b0, r_rem[j-1]} - {1'b0, (CW'(r_den[j-1]) << B)};

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= w_dif[CW] ? r_rem[j-1] : w_dif[CW-1:0];
                r_q[j]   <= w_dif[CW] ? r_q[j-1] : (r_q[j-1] | (W'(1) << B));
                r_den[j] <= r_den[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    assign o_q   = r_q[W];
    assign o_ovf = r_ovf[W];
    assign o_neg = r_neg[W];

endmodule

// ===== design/matrix_inverse_3x3.sv =====
// channel   dir  signals                               moves
// i_in      in   valid ready in_r1c1..in_r3c3         one matrix word
// o_out     out  valid ready out_r1c1..out_r3c3 flags one inverse word
// i_cfg     in   valid ready data                      threshold register write
//
// six stages of minors and determinant, then ENTRY_WIDTH + 1 stages of the per-entry
// restoring dividers, then the output register. one word per cycle is taken while o_out
// does not stall; the divider lanes, one quotient bit per stage, set that figure. a stall
// on o_out fills bubbles first, so i_in.ready drops only when every stage holds a word.
// reset clears the stage valids and loads the threshold with 1.
module matrix_inverse_3x3 #(
    parameter int ENTRY_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mi3_in_if.sink          i_in,
    mi3_out_if.source       o_out,
    mi3_cfg_if.sink         i_cfg
);

    localparam int W  = ENTRY_WIDTH;
    localparam int NE = mi3_pkg::NUM_ENT;
    localparam int FS = 6;
    localparam int S  = FS + W + 2;
    localparam int NW = 2 * W + 1 + 2 * FRAC_BITS;
    localparam int MW = 3 * W + 2;

    logic [mi3_pkg::THR_WIDTH-1:0] r_thr;
    logic [S-1:0]                  r_vld;
    logic [S-1:0]                  w_en;

    logic signed [W-1:0] w_ent  [NE];
    logic [MW-1:0]       w_mag;
    logic [NW-1:0]       w_num  [NE];
    logic                w_neg  [NE];
    logic                w_sing;
    logic signed [W-1:0] w_fent [NE];
    logic [W-1:0]        w_q    [NE];
    logic                w_ovf  [NE];
    logic                w_qneg [NE];

    logic signed [W-1:0] r_pe [W+1][NE];
    logic                r_ps [W+1];

    logic signed [W-1:0] n_out [NE];
    logic                n_sat;
    logic signed [W-1:0] r_out [NE];
    logic                r_sing;
    logic                r_sat;

    // threshold register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mi3_pkg::THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    // stage enables, a stage moves when empty or when the next one moves
    always_comb begin
        w_en[S-1] = !r_vld[S-1] || o_out.ready;
        for (int k = S - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < S; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    assign w_ent[0] = i_in.in_r1c1;
    assign w_ent[1] = i_in.in_r1c2;
    assign w_ent[2] = i_in.in_r1c3;
    assign w_ent[3] = i_in.in_r2c1;
    assign w_ent[4] = i_in.in_r2c2;
    assign w_ent[5] = i_in.in_r2c3;
    assign w_ent[6] = i_in.in_r3c1;
    assign w_ent[7] = i_in.in_r3c2;
    assign w_ent[8] = i_in.in_r3c3;

    // adjugate, determinant and singular test
    mi3_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_en   (w_en[FS-1:0]),
        .i_ent  (w_ent),
        .i_thr  (r_thr),
        .o_mag  (w_mag),
        .o_num  (w_num),
        .o_neg  (w_neg),
        .o_sing (w_sing),
        .o_ent  (w_fent)
    );

    // one divider lane per inverse entry
    for (genvar k = 0; k < NE; k++) begin : g_lane
        mi3_div_lane #(
            .W  (W),
            .NW (NW),
            .MW (MW)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en[FS+W:FS]),
            .i_num (w_num[k]),
            .i_den (w_mag),
            .i_neg (w_neg[k]),
            .o_q   (w_q[k]),
            .o_ovf (w_ovf[k]),
            .o_neg (w_qneg[k])
        );
    end

    // entries and singular flag travel beside the lanes
    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= W; j++) begin
            if (w_en[FS+j]) begin
                if (j == 0) begin
                    r_pe[j] <= w_fent;
                    r_ps[j] <= w_sing;
                end else begin
                    r_pe[j] <= r_pe[(j == 0) ? 0 : j - 1];
                    r_ps[j] <= r_ps[(j == 0) ? 0 : j - 1];
                end
            end
        end
    end

    // merge: sign, saturation, pass-through when singular
    always_comb begin
        n_sat = 1'b0;
        for (int k = 0; k < NE; k++) begin
            if (w_qneg[k]) begin
                if (w_ovf[k] || (w_q[k] > (W'(1) << (W - 1)))) begin
                    n_out[k] = $signed(W'(1) << (W - 1));
                    n_sat    = 1'b1;
                end else begin
                    n_out[k] = $signed(W'(-w_q[k]));
                end
            end else begin
                if (w_ovf[k] || w_q[k][W-1]) begin
                    n_out[k] = $signed((W'(1) << (W - 1)) - W'(1));
                    n_sat    = 1'b1;
                end else begin
                    n_out[k] = $signed(w_q[k]);
                end
            end
            if (r_ps[W]) begin
                n_out[k] = r_pe[W][k];
            end
        end
        if (r_ps[W]) begin
            n_sat = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en[S-1]) begin
            r_out  <= n_out;
            r_sing <= r_ps[W];
            r_sat  <= n_sat;
        end
    end

    assign o_out.valid     = r_vld[S-1];
    assign o_out.out_r1c1  = r_out[0];
    assign o_out.out_r1c2  = r_out[1];
    assign o_out.out_r1c3  = r_out[2];
    assign o_out.out_r2c1  = r_out[3];
    assign o_out.out_r2c2  = r_out[4];
    assign o_out.out_r2c3  = r_out[5];
    assign o_out.out_r3c1  = r_out[6];
    assign o_out.out_r3c2  = r_out[7];
    assign o_out.out_r3c3  = r_out[8];
    assign o_out.singular  = r_sing;
    assign o_out.saturated = r_sat;

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    localparam int EW      = 32;
    localparam int LATENCY = EW + 8;

    typedef struct {
        logic signed [EW-1:0] e [mi3_pkg::NUM_ENT];
    } matrix_t;

    typedef struct {
        logic signed [EW-1:0] e [mi3_pkg::NUM_ENT];
        logic                 singular;
        logic                 saturated;
    } inverse_t;

    // expected inverse words and the adjugate predictor
    class inverse_board;
        inverse_t                      pending_q [$];
        logic [mi3_pkg::THR_WIDTH-1:0] threshold;
        int                            errors;
        int                            checked;

        function new();
            threshold = mi3_pkg::THR_RESET;
            errors    = 0;
            checked   = 0;
        endfunction

        function inverse_t predict_inverse(matrix_t m);
            logic signed [127:0] mm [mi3_pkg::NUM_ENT];
            logic signed [127:0] adj [mi3_pkg::NUM_ENT];
            logic signed [127:0] det;
            logic [127:0]        mag, lim, num, q;
            logic [127:0]        half;
            logic                neg;
            inverse_t            r;
            half = 128'(1) << (EW - 1);
            for (int i = 0; i < mi3_pkg::NUM_ENT; i++) mm[i] = m.e[i];
            for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
                adj[k] = mm[mi3_pkg::MIN_A[k]] * mm[mi3_pkg::MIN_B[k]]
                       - mm[mi3_pkg::MIN_C[k]] * mm[mi3_pkg::MIN_D[k]];
            det = 0;
            for (int k = 0; k < mi3_pkg::DET_TERMS; k++)
                det = det + mm[k] * adj[mi3_pkg::DET_ADJ[k]];
            mag = det < 0 ? -det : det;
            lim = 128'(threshold) << 32;
            r.saturated = 1'b0;
            // too small a determinant: pass the matrix through
            if (mag == 0 || mag < lim) begin
                for (int i = 0; i < mi3_pkg::NUM_ENT; i++) r.e[i] = m.e[i];
                r.singular = 1'b1;
                return r;
            end
            r.singular = 1'b0;
            for (int i = 0; i < mi3_pkg::NUM_ENT; i++) begin
                num = adj[i] < 0 ? -adj[i] : adj[i];
                num = num << 32;
                q   = num / mag;
                neg = (adj[i] < 0) != (det < 0);
                if (neg) begin
                    if (q > half) begin
                        q = half;
                        r.saturated = 1'b1;
                    end
                    r.e[i] = -q[EW-1:0];
                end else begin
                    if (q > half - 1) begin
                        q = half - 1;
                        r.saturated = 1'b1;
                    end
                    r.e[i] = q[EW-1:0];
                end
            end
            return r;
        endfunction

        function void note_matrix(matrix_t m);
            pending_q.push_back(predict_inverse(m));
        endfunction

        function void check_inverse(inverse_t got);
            inverse_t want;
            checked++;
            if (pending_q.size() == 0) begin
                $error("inverse word with nothing expected");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            for (int i = 0; i < mi3_pkg::NUM_ENT; i++)
                if (got.e[i] !== want.e[i]) begin
                    $error("out_r%0dc%0d expected %0d got %0d", i / 3 + 1, i % 3 + 1,
                           want.e[i], got.e[i]);
                    errors++;
                end
            if (got.singular !== want.singular) begin
                $error("singular expected %0b got %0b", want.singular, got.singular);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated expected %0b got %0b", want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   busy_mode;
    int   settings;

    inverse_board board;

    mi3_in_if  #(EW) in_ch ();
    mi3_out_if #(EW) out_ch ();
    mi3_cfg_if       cfg_ch ();

    matrix_inverse_3x3 dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones, none in busy stretches
    function automatic int pick_gap();
        int r;
        if (busy_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver with random stalls
    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                stall--;
            end else begin
                out_ch.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        inverse_t got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.e[0] = out_ch.out_r1c1;
            got.e[1] = out_ch.out_r1c2;
            got.e[2] = out_ch.out_r1c3;
            got.e[3] = out_ch.out_r2c1;
            got.e[4] = out_ch.out_r2c2;
            got.e[5] = out_ch.out_r2c3;
            got.e[6] = out_ch.out_r3c1;
            got.e[7] = out_ch.out_r3c2;
            got.e[8] = out_ch.out_r3c3;
            got.singular  = out_ch.singular;
            got.saturated = out_ch.saturated;
            board.check_inverse(got);
        end
    end

    // one matrix word, held until taken
    task automatic send_matrix(matrix_t m);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid   = 1'b1;
        in_ch.in_r1c1 = m.e[0];
        in_ch.in_r1c2 = m.e[1];
        in_ch.in_r1c3 = m.e[2];
        in_ch.in_r2c1 = m.e[3];
        in_ch.in_r2c2 = m.e[4];
        in_ch.in_r2c3 = m.e[5];
        in_ch.in_r3c1 = m.e[6];
        in_ch.in_r3c2 = m.e[7];
        in_ch.in_r3c3 = m.e[8];
        do @(posedge clk); while (!in_ch.ready);
        board.note_matrix(m);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // threshold write, only with the pipeline empty
    task automatic write_threshold(logic [mi3_pkg::THR_WIDTH-1:0] thr);
        drain();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = thr;
        do @(posedge clk); while (!cfg_ch.ready);
        board.threshold = thr;
        settings++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic matrix_t diag3(int a, int b, int c);
        matrix_t m;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++) m.e[i] = '0;
        m.e[0] = a;
        m.e[4] = b;
        m.e[8] = c;
        return m;
    endfunction

    function automatic matrix_t fill_all(logic signed [EW-1:0] v);
        matrix_t m;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++) m.e[i] = v;
        return m;
    endfunction

    // random matrix: some full range, some mid range (at times with a diagonal boost), some small, some rank deficient
    function automatic matrix_t random_matrix();
        matrix_t m;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++) begin
            if (mode < 3) m.e[i] = $urandom;
            else if (mode < 7) m.e[i] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            else m.e[i] = $signed($urandom_range(0, 1 << 13)) - (1 << 12);
        end
        if (mode >= 3 && mode < 7 && $urandom_range(0, 1))
            for (int i = 0; i < 3; i++) m.e[i * 4] = m.e[i * 4] + (1 << 16);
        if (mode == 9) begin
            // repeated row gives a zero determinant
            for (int i = 0; i < 3; i++) m.e[6 + i] = m.e[i];
        end
        return m;
    endfunction

    // stimulus
    initial begin
        matrix_t m;
        logic [mi3_pkg::THR_WIDTH-1:0] thr_list [4];
        board = new();
        settings = 1;
        busy_mode = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        m = fill_all('0);
        in_ch.in_r1c1 = '0; in_ch.in_r1c2 = '0; in_ch.in_r1c3 = '0;
        in_ch.in_r2c1 = '0; in_ch.in_r2c2 = '0; in_ch.in_r2c3 = '0;
        in_ch.in_r3c1 = '0; in_ch.in_r3c2 = '0; in_ch.in_r3c3 = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, zero, extremes, exact minimum, clipping
        send_matrix(diag3(1 << 16, 1 << 16, 1 << 16));
        send_matrix(fill_all('0));
        send_matrix(fill_all(32'sh8000_0000));
        send_matrix(fill_all(32'sh7fff_ffff));
        send_matrix(diag3(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
        send_matrix(diag3(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_matrix(diag3(-2, 1 << 24, 1 << 24));
        send_matrix(diag3(2, -(1 << 24), 1 << 24));
        send_matrix(diag3(1, 1 << 24, 1 << 24));
        send_matrix(diag3(-1, 1 << 24, 1 << 24));
        send_matrix(diag3(1, 1, 1));
        send_matrix(diag3(1 << 16, 1 << 16, 0));
        send_matrix(diag3(-(1 << 16), 2 << 16, 3 << 16));
        write_threshold('0);
        send_matrix(fill_all('0));
        send_matrix(diag3(1, 1, 1));
        send_matrix(diag3(1, 1 << 24, 1 << 24));
        write_threshold({mi3_pkg::THR_WIDTH{1'b1}});
        send_matrix(diag3(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_matrix(diag3(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_matrix(diag3(1 << 16, 1 << 16, 1 << 16));

        // random phases over several thresholds
        thr_list[0] = mi3_pkg::THR_RESET;
        thr_list[1] = '0;
        thr_list[2] = mi3_pkg::THR_WIDTH'($urandom_range(2, 1 << 20));
        thr_list[3] = {mi3_pkg::THR_WIDTH{1'b1}};
        for (int p = 0; p < 4; p++) begin
            write_threshold(thr_list[p]);
            for (int n = 0; n < 400; n++) begin
                if (n % 100 == 0) busy_mode = ($urandom_range(0, 3) == 0);
                if (n == 200) drain();
                send_matrix(random_matrix());
            end
            busy_mode = 1'b0;
        end
        drain();
        $display("Checked %0d inverse words across %0d threshold settings",
                 board.checked, settings);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end
endmodule
